FILE: rtl/slbd_pkg.sv
package slbd_pkg;

   localparam int LEVEL_W     = 16;
   localparam int DELTA_W     = 11;
   localparam int MAX_RESULTS = 64;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef logic signed [LEVEL_W-1:0] level_type;
   typedef logic        [DELTA_W-1:0] delta_type;
   typedef logic        [CNT_W-1:0]   count_type;

endpackage

FILE: rtl/slbd_mul.sv
module slbd_mul import slbd_pkg::*; #(
   parameter int A_W = 22,
   parameter int B_W = 27
) (
   input  logic                     clock,
   input  logic signed [A_W-1:0]    op_a,
   input  logic signed [B_W-1:0]    op_b,
   output logic signed [A_W+B_W-1:0] prod_ff
);

   logic signed [A_W+B_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: rtl/step_level_box_decimator.sv
// step_level_box_decimator
// Integrate-and-dump decimator for a piecewise-constant Q1.15 level.
// Request channel (req_valid / req_stall): one beat holds the current level for
// req_delta_ticks sub-ticks, then switches to req_new_level. A beat is taken at
// an edge with req_valid high and req_stall low.
// Response channel (rsp_valid / rsp_stall): one beat per completed window of
// TICKS_PER_SAMPLE sub-ticks, carrying floor(window sum / TICKS_PER_SAMPLE) and
// rsp_last on the final beat of a request; at most 64 beats per request, any
// further windows are integrated and dropped.
// Sequencing: one shared multiplier, registered, does both the level * ticks term
// and the reciprocal multiply that divides the window sum. A run of ticks
// inside one window passes through CHUNK and ACC; each completed window then
// passes through DIV and EMIT, and waits in EMIT while the response side stalls.
// A zero-length request is taken in IDLE and never leaves it; req_stall is high
// until a request is done.
// The response register lets a finished beat wait while the next request is
// taken; while rsp_stall is high and a new beat is ready, the sequencer waits.
// Reset (synchronous, active high) clears the level, window sum and phase.
module step_level_box_decimator import slbd_pkg::*; #(
   parameter int TICKS_PER_SAMPLE = 28
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic        [DELTA_W-1:0] req_delta_ticks,
   input  logic signed [LEVEL_W-1:0] req_new_level,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [LEVEL_W-1:0] rsp_sample,
   output logic                      rsp_last
);

   localparam int TAKE_W = $clog2(TICKS_PER_SAMPLE + 1);
   localparam int PH_W   = $clog2(TICKS_PER_SAMPLE);
   localparam int SUM_W  = LEVEL_W + TAKE_W;
   localparam int NUM_W  = SUM_W;
   localparam int K      = NUM_W + TAKE_W;
   localparam int A_W    = NUM_W + 1;
   localparam int B_W    = K + 1;
   localparam int P_W    = A_W + B_W;
   localparam longint unsigned RECIP =
      ((64'd1 << K) + TICKS_PER_SAMPLE - 1) / TICKS_PER_SAMPLE;
   localparam logic [K-1:0]      RECIP_K = RECIP[K-1:0];
   localparam logic [NUM_W-1:0]  BIAS    =
      NUM_W'(longint'(TICKS_PER_SAMPLE) * (64'd1 << (LEVEL_W - 1)));
   localparam logic [TAKE_W-1:0] T_TAKE  = TAKE_W'(TICKS_PER_SAMPLE);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHUNK,
      ST_ACC,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type               state_ff,     state_in;
   level_type               level_ff,     level_in;
   level_type               next_lvl_ff,  next_lvl_in;
   logic signed [SUM_W-1:0] sum_ff,       sum_in;
   logic [PH_W-1:0]         phase_ff,     phase_in;
   delta_type               remain_ff,    remain_in;
   logic [TAKE_W-1:0]       take_ff,      take_in;
   count_type               count_ff,     count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   level_type               rsp_sample_ff, rsp_sample_in;
   logic                    rsp_last_ff,  rsp_last_in;

   logic signed [A_W-1:0]   mul_a;
   logic signed [B_W-1:0]   mul_b;
   logic signed [P_W-1:0]   prod_ff;
   logic [TAKE_W-1:0]       gap;
   logic [TAKE_W-1:0]       take_now;
   logic [TAKE_W-1:0]       phase_end;
   logic                    win_done;
   logic                    slot_free;
   logic [NUM_W-1:0]        biased;
   logic [LEVEL_W-1:0]      quot;

   slbd_mul #(
      .A_W (A_W),
      .B_W (B_W)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   assign gap       = T_TAKE - TAKE_W'(phase_ff);
   assign take_now  = (DELTA_W'(gap) >= remain_ff) ? TAKE_W'(remain_ff) : gap;
   assign phase_end = TAKE_W'(phase_ff) + take_ff;
   assign win_done  = (phase_end == T_TAKE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign biased    = NUM_W'(sum_ff) + BIAS;
   // offset quotient lies in 0..65535, flipping the msb removes the bias
   assign quot      = prod_ff[K +: LEVEL_W] ^ {1'b1, {(LEVEL_W-1){1'b0}}};

   // divide operands held through emit so the quotient stays put while stalled
   always_comb begin
      if (state_ff inside {ST_DIV, ST_EMIT}) begin
         mul_a = A_W'($signed({1'b0, biased}));
         mul_b = B_W'($signed({1'b0, RECIP_K}));
      end else begin
         mul_a = A_W'(level_ff);
         mul_b = B_W'($signed({1'b0, take_now}));
      end
   end

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      next_lvl_in   = next_lvl_ff;
      sum_in        = sum_ff;
      phase_in      = phase_ff;
      remain_in     = remain_ff;
      take_in       = take_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               remain_in   = req_delta_ticks;
               next_lvl_in = req_new_level;
               count_in    = '0;
               if (req_delta_ticks == '0) begin
                  level_in = req_new_level;
               end else begin
                  state_in = ST_CHUNK;
               end
            end
         end
         ST_CHUNK: begin
            take_in  = take_now;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in    = sum_ff + prod_ff[SUM_W-1:0];
            remain_in = remain_ff - DELTA_W'(take_ff);
            if (win_done) begin
               phase_in = '0;
               state_in = ST_DIV;
            end else begin
               phase_in = PH_W'(phase_end);
               level_in = next_lvl_ff;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               sum_in = '0;
               if (count_ff < CNT_W'(MAX_RESULTS)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_sample_in = quot;
                  rsp_last_in   = (remain_ff < DELTA_W'(TICKS_PER_SAMPLE))
                                  || (count_ff == CNT_W'(MAX_RESULTS - 1));
                  count_in      = count_ff + CNT_W'(1);
               end
               if (remain_ff == '0) begin
                  level_in = next_lvl_ff;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_CHUNK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         sum_ff       <= '0;
         phase_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         sum_ff       <= sum_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      next_lvl_ff   <= next_lvl_in;
      remain_ff     <= remain_in;
      take_ff       <= take_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff < PH_W'(TICKS_PER_SAMPLE - 1) || phase_ff == PH_W'(TICKS_PER_SAMPLE - 1))
      else $error("window phase out of range");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RESULTS))
      else $error("beat count above cap");

   // an open window at the end of a chunk means the request is used up
   a_partial_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && !win_done) |-> remain_ff == DELTA_W'(take_ff))
      else $error("partial window with ticks left");

   a_beat_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("response beat not from emit");

endmodule

FILE: tb/step_level_box_decimator_tb.sv
module step_level_box_decimator_tb;
   import slbd_pkg::*;

   localparam int TICKS = 28;
   localparam int LIMIT = 5_000_000;
   localparam int N_DIRECTED = 17;
   localparam int BEAT_DEPTH = 32768;

   typedef struct packed {
      delta_type  delta;
      level_type  level;
      logic       typed;
      logic [6:0] n_typed;
      level_type  typed_sample;
   } step_row_type;

   typedef struct {
      level_type sample;
      logic      last;
   } window_beat_type;

   // typed rows carry their window averages, the rest go through the predictor
   localparam step_row_type DIRECTED [N_DIRECTED] = '{
      '{0,    32767,  1, 0,  0},
      '{28,   -32768, 1, 1,  32767},
      '{56,   0,      1, 2,  -32768},
      '{10,   100,    1, 0,  0},
      '{18,   -1,     0, 0,  0},
      '{1,    5,      0, 0,  0},
      '{27,   5,      0, 0,  0},
      '{2047, -32768, 1, 64, 5},
      '{1791, 32767,  0, 0,  0},
      '{0,    1,      1, 0,  0},
      '{0,    -1,     1, 0,  0},
      '{1365, 21845,  0, 0,  0},
      '{682,  -21846, 0, 0,  0},
      '{1,    -32768, 0, 0,  0},
      '{27,   32767,  0, 0,  0},
      '{1023, 0,      0, 0,  0},
      '{1024, -7,     0, 0,  0}
   };

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   delta_type req_delta_ticks = '0;
   level_type req_new_level = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   level_type rsp_sample;
   logic      rsp_last;

   window_beat_type pending_windows [BEAT_DEPTH];
   int              beat_wr = 0;
   int              beat_rd = 0;
   int              mismatches = 0;

   level_type box_level = '0;
   longint    box_sum = 0;
   int        box_phase = 0;

   step_level_box_decimator #(.TICKS_PER_SAMPLE(TICKS)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_delta_ticks (req_delta_ticks),
      .req_new_level   (req_new_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_last        (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // box average of the held level over each completed window, capped per step
   function automatic int integrate_level(input delta_type d, input level_type l,
                                          input bit keep);
      int              left;
      int              take;
      int              n;
      longint          avg;
      window_beat_type b;
      left = d;
      n = 0;
      while (left > 0) begin
         take = TICKS - box_phase;
         if (take > left)
            take = left;
         box_sum += longint'(box_level) * take;
         box_phase += take;
         left -= take;
         if (box_phase >= TICKS) begin
            if (box_sum >= 0)
               avg = box_sum / TICKS;
            else
               avg = -((-box_sum + TICKS - 1) / TICKS);
            if (n < MAX_RESULTS) begin
               if (keep) begin
                  b.sample = avg[LEVEL_W-1:0];
                  b.last = 1'b0;
                  pending_windows[beat_wr] = b;
                  beat_wr++;
               end
               n++;
            end
            box_sum = 0;
            box_phase = 0;
         end
      end
      if (keep && n > 0)
         pending_windows[beat_wr - 1].last = 1'b1;
      box_level = l;
      return n;
   endfunction

   function automatic int pick_gap(input int idx);
      int r;
      r = $urandom_range(0, 99);
      if ((idx / 40) % 5 == 0 || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   task automatic drive_level_step(input delta_type d, input level_type l, input int gap,
                                   input bit keep);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_delta_ticks <= d;
      req_new_level <= l;
      do @(posedge clock); while (req_stall);
      void'(integrate_level(d, l, keep));
   endtask

   initial begin
      window_beat_type b;
      delta_type       d;
      level_type       l;
      int              r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         drive_level_step(DIRECTED[i].delta, DIRECTED[i].level, pick_gap(i + 40),
                          !DIRECTED[i].typed);
         if (DIRECTED[i].typed) begin
            for (int k = 0; k < DIRECTED[i].n_typed; k++) begin
               b.sample = DIRECTED[i].typed_sample;
               b.last = (k == DIRECTED[i].n_typed - 1);
               pending_windows[beat_wr] = b;
               beat_wr++;
            end
         end
      end

      for (int i = 0; i < 400; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15)
            d = '0;
         else if (r < 60)
            d = DELTA_W'($urandom_range(1, 60));
         else if (r < 85)
            d = DELTA_W'($urandom_range(61, 400));
         else if (r < 95)
            d = DELTA_W'($urandom_range(401, 1791));
         else
            d = DELTA_W'($urandom_range(1792, 2047));
         r = $urandom_range(0, 99);
         if (r < 4)
            l = 16'sh7fff;
         else if (r < 8)
            l = 16'sh8000;
         else if (r < 10)
            l = '0;
         else
            l = LEVEL_W'($urandom);
         drive_level_step(d, l, pick_gap(i), 1'b1);
      end
      req_valid <= 1'b0;

      while (beat_rd < beat_wr)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // result side: check each beat, then pick the next stall
   int stall_left = 0;
   int rsp_cycles = 0;
   always @(posedge clock) begin
      window_beat_type e;
      int              r;
      rsp_cycles++;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (beat_rd == beat_wr) begin
               $display("%0t: unexpected beat, sample %0d last %0b", $time, rsp_sample,
                        rsp_last);
               mismatches++;
            end else begin
               e = pending_windows[beat_rd];
               beat_rd++;
               if (rsp_sample !== e.sample) begin
                  $display("%0t: sample expected %0d got %0d", $time, e.sample, rsp_sample);
                  mismatches++;
               end
               if (rsp_last !== e.last) begin
                  $display("%0t: last expected %0b got %0b", $time, e.last, rsp_last);
                  mismatches++;
               end
            end
         end
         r = $urandom_range(0, 99);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if ((rsp_cycles / 1500) % 4 == 0 || r < 70) begin
            rsp_stall <= 1'b0;
         end else if (r < 92) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(10, 40);
         end
      end
   end

   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
